// ----- src/assert_macros.svh -----
// Assertion macros shared by the grid cost map RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define GCM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define GCM_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- src/gcm_pkg.sv -----
// Types, constants and controller/datapath interface structs of the grid cost map.
package gcm_pkg;

	localparam int MAX_ROWS  = 64;
	localparam int MAX_COLS  = 64;
	localparam int COST_BITS = 15;

	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ADDR_W    = ROW_W + COL_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int WORD_W    = COST_BITS + 1;
	localparam int CFG_W     = 7;
	localparam int COST_IN_W = 16;
	localparam int KIND_W    = 3;
	localparam int STATUS_W  = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_FILL  = 3'd0,
		KIND_COST  = 3'd1,
		KIND_OBST  = 3'd2,
		KIND_READ  = 3'd3,
		KIND_NEIGH = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_NEG   = 2'd2
	} status_t;

	typedef enum logic {
		CFG_ROWS = 1'b0,
		CFG_COLS = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_FILL,
		S_RESP,
		S_NB_ADDR,
		S_NB_CHECK,
		S_NB_FINAL
	} state_t;

	typedef struct packed {
		logic capture;
		logic clear_wr;
		logic fill_wr;
		logic cell_wr;
		logic cell_rd;
		logic nb_issue;
		logic nb_next;
		logic nb_take;
		logic emit_single;
		logic emit_final;
	} dp_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              negative;
		logic              in_map;
		logic              clear_last;
		logic              fill_last;
		logic              cand_valid;
		logic              nb_last;
		logic              rd_obst;
		logic              pend_valid;
		logic              out_free;
	} dp_stat_t;

endpackage

// ----- src/gcm_ctrl.sv -----
// Controller state machine that sequences clearing, fills, cell accesses and expansion.
`include "assert_macros.svh"

module gcm_ctrl import gcm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_next;
	logic   nb_block;

	// A qualifying neighbor pushes the held one out, which needs room at the output.
	assign nb_block = !stat.rd_obst && stat.pend_valid && !stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clear_last) state_next = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_next = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (stat.kind)
					KIND_FILL:  state_next = stat.negative ? S_RESP : S_FILL;
					KIND_COST:  state_next = S_RESP;
					KIND_OBST:  state_next = S_RESP;
					KIND_READ:  state_next = S_RESP;
					KIND_NEIGH: state_next = stat.in_map ? S_NB_ADDR : S_RESP;
					default:    state_next = S_IDLE;
				endcase
			end
			S_FILL: begin
				if (stat.fill_last) state_next = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) state_next = S_IDLE;
			end
			S_NB_ADDR: begin
				if (stat.cand_valid) state_next = S_NB_CHECK;
				else if (stat.nb_last) state_next = S_NB_FINAL;
			end
			S_NB_CHECK: begin
				if (!nb_block) state_next = stat.nb_last ? S_NB_FINAL : S_NB_ADDR;
			end
			S_NB_FINAL: begin
				if (stat.out_free) state_next = S_IDLE;
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_DISPATCH: begin
				cmd.cell_wr = ((stat.kind == KIND_COST) && !stat.negative && stat.in_map)
					|| ((stat.kind == KIND_OBST) && stat.in_map);
				cmd.cell_rd = (stat.kind == KIND_READ) && stat.in_map;
			end
			S_FILL: begin
				cmd.fill_wr = 1'b1;
			end
			S_RESP: begin
				cmd.emit_single = stat.out_free;
			end
			S_NB_ADDR: begin
				cmd.nb_issue = stat.cand_valid;
				cmd.nb_next  = !stat.cand_valid && !stat.nb_last;
			end
			S_NB_CHECK: begin
				cmd.nb_take = !nb_block;
				cmd.nb_next = !nb_block && !stat.nb_last;
			end
			S_NB_FINAL: begin
				cmd.emit_final = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`GCM_ASSERT(a_check_follows_read, state_q == S_NB_CHECK |-> $past(state_q) == S_NB_ADDR || $past(state_q) == S_NB_CHECK, "neighbour check without a preceding read")
	`GCM_NEVER(a_ready_only_idle, in_ready && state_q != S_IDLE, "input ready outside idle")
	`GCM_ASSERT(a_capture_on_accept, cmd.capture |-> in_valid && in_ready, "capture without handshake")

endmodule

// ----- src/gcm_dp.sv -----
// Datapath: cell memory, configuration registers, sweep and window counters, output register.
`include "assert_macros.svh"

module gcm_dp import gcm_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dp_cmd_t                     cmd,
	output dp_stat_t                    stat,
	input  logic [KIND_W-1:0]           kind,
	input  logic [ROW_W-1:0]            row,
	input  logic [COL_W-1:0]            col,
	input  logic signed [COST_IN_W-1:0] cost_value,
	input  logic                        diagonal,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [STATUS_W-1:0]         status,
	output logic [COST_BITS-1:0]        cell_cost,
	output logic                        is_obstacle,
	output logic [ROW_W-1:0]            out_row,
	output logic [COL_W-1:0]            out_col,
	output logic                        found,
	output logic                        last
);

	localparam logic [1:0]           D_LO     = 2'd0;
	localparam logic [1:0]           D_MID    = 2'd1;
	localparam logic [1:0]           D_HI     = 2'd2;
	localparam logic [COST_BITS-1:0] COST_MAX = '1;

	// Configuration.
	logic [CFG_W-1:0] rows_cfg_q, cols_cfg_q;
	logic [CFG_W-1:0] nr_eff, nc_eff;

	// Captured word.
	logic [KIND_W-1:0]    kind_q;
	logic [ROW_W-1:0]     row_q;
	logic [COL_W-1:0]     col_q;
	logic [COST_BITS-1:0] cost_q;
	logic                 neg_q;
	logic                 diag_q;
	logic [COST_IN_W-1:0] cost_mag;
	logic [COST_BITS-1:0] cost_sat;

	// Memory.
	logic [WORD_W-1:0] mem_q [0:MEM_DEPTH-1];
	logic [WORD_W-1:0] rdata_q;
	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [WORD_W-1:0] wr_data;

	// Sweep counters for clearing and fill.
	logic [ROW_W-1:0] sweep_r_q;
	logic [COL_W-1:0] sweep_c_q;
	logic             sweep_col_end, sweep_row_end;

	// Neighbor window.
	logic [1:0]       dr_q, dc_q;
	logic [ROW_W-1:0] cand_r, cand_r_q, pend_r_q;
	logic [COL_W-1:0] cand_c, cand_c_q, pend_c_q;
	logic             pend_valid_q;
	logic             row_at_end, col_at_end;
	logic             row_ok, col_ok, cand_valid;
	logic             in_map, rd_obst, emit_mid, emit, out_free;

	// Output register.
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [COST_BITS-1:0] cell_cost_q;
	logic                 is_obstacle_q;
	logic [ROW_W-1:0]     out_row_q;
	logic [COL_W-1:0]     out_col_q;
	logic                 found_q;
	logic                 last_q;

	// Single-result fields.
	status_t              single_status;
	logic                 single_read;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= CFG_W'(MAX_ROWS);
			cols_cfg_q <= CFG_W'(MAX_COLS);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ROWS: rows_cfg_q <= cfg_data;
				CFG_COLS: cols_cfg_q <= cfg_data;
				default:  rows_cfg_q <= rows_cfg_q;
			endcase
		end
	end

	// A zero register acts as one, a value above the maximum acts as the maximum.
	always_comb begin
		if (rows_cfg_q == '0) nr_eff = CFG_W'(1);
		else if (rows_cfg_q > CFG_W'(MAX_ROWS)) nr_eff = CFG_W'(MAX_ROWS);
		else nr_eff = rows_cfg_q;
		if (cols_cfg_q == '0) nc_eff = CFG_W'(1);
		else if (cols_cfg_q > CFG_W'(MAX_COLS)) nc_eff = CFG_W'(MAX_COLS);
		else nc_eff = cols_cfg_q;
	end

	assign cost_mag = {1'b0, cost_value[COST_IN_W-2:0]};
	assign cost_sat = (cost_mag > COST_IN_W'(COST_MAX)) ? COST_MAX
		: cost_value[COST_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			row_q  <= row;
			col_q  <= col;
			cost_q <= cost_sat;
			neg_q  <= cost_value[COST_IN_W-1];
			diag_q <= diagonal;
		end
	end

	assign in_map = (CFG_W'(row_q) < nr_eff) && (CFG_W'(col_q) < nc_eff);

	// Memory ports.
	always_comb begin
		wr_en   = cmd.clear_wr || cmd.fill_wr || cmd.cell_wr;
		wr_addr = {sweep_r_q, sweep_c_q};
		wr_data = '0;
		if (cmd.fill_wr) begin
			wr_data = {1'b0, cost_q};
		end else if (cmd.cell_wr) begin
			wr_addr = {row_q, col_q};
			wr_data = (kind_q == KIND_OBST) ? {1'b1, {COST_BITS{1'b0}}} : {1'b0, cost_q};
		end
		rd_en   = cmd.cell_rd || cmd.nb_issue;
		rd_addr = cmd.nb_issue ? {cand_r, cand_c} : {row_q, col_q};
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem_q[rd_addr];
	end

	assign rd_obst = rdata_q[COST_BITS];

	// The clearing pass covers the whole array; a fill covers the map in use.
	assign sweep_col_end = cmd.clear_wr ? (sweep_c_q == COL_W'(MAX_COLS - 1))
		: ((CFG_W'(sweep_c_q) + CFG_W'(1)) == nc_eff);
	assign sweep_row_end = cmd.clear_wr ? (sweep_r_q == ROW_W'(MAX_ROWS - 1))
		: ((CFG_W'(sweep_r_q) + CFG_W'(1)) == nr_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_r_q <= '0;
			sweep_c_q <= '0;
		end else if (cmd.clear_wr || cmd.fill_wr) begin
			if (sweep_col_end) begin
				sweep_c_q <= '0;
				sweep_r_q <= sweep_row_end ? '0 : sweep_r_q + ROW_W'(1);
			end else begin
				sweep_c_q <= sweep_c_q + COL_W'(1);
			end
		end
	end

	// Window position (dr_q, dc_q) walks a 3x3 block around the cell in row-major order.
	assign cand_r     = row_q + ROW_W'(dr_q) - ROW_W'(1);
	assign cand_c     = col_q + COL_W'(dc_q) - COL_W'(1);
	assign row_at_end = (CFG_W'(row_q) + CFG_W'(1)) == nr_eff;
	assign col_at_end = (CFG_W'(col_q) + CFG_W'(1)) == nc_eff;
	assign row_ok     = (dr_q != D_LO || row_q != '0) && (dr_q != D_HI || !row_at_end);
	assign col_ok     = (dc_q != D_LO || col_q != '0) && (dc_q != D_HI || !col_at_end);
	assign cand_valid = row_ok && col_ok && !(dr_q == D_MID && dc_q == D_MID)
		&& (diag_q || dr_q == D_MID || dc_q == D_MID);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dr_q <= D_LO;
			dc_q <= D_LO;
		end else if (cmd.capture) begin
			dr_q <= D_LO;
			dc_q <= D_LO;
		end else if (cmd.nb_next) begin
			if (dc_q == D_HI) begin
				dc_q <= D_LO;
				dr_q <= dr_q + 2'd1;
			end else begin
				dc_q <= dc_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.nb_issue) begin
			cand_r_q <= cand_r;
			cand_c_q <= cand_c;
		end
		if (cmd.nb_take && !rd_obst) begin
			pend_r_q <= cand_r_q;
			pend_c_q <= cand_c_q;
		end
	end

	// One free neighbor is held back until the next one, or the end, decides its last flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.capture || cmd.emit_final) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.nb_take && !rd_obst) begin
			pend_valid_q <= 1'b1;
		end
	end

	always_comb begin
		if (neg_q && (kind_q == KIND_FILL || kind_q == KIND_COST)) single_status = ST_NEG;
		else if (kind_q != KIND_FILL && !in_map) single_status = ST_RANGE;
		else single_status = ST_OK;
		single_read = (kind_q == KIND_READ) && in_map;
	end

	assign out_free = !out_valid_q || out_ready;
	assign emit_mid = cmd.nb_take && !rd_obst && pend_valid_q;
	assign emit     = cmd.emit_single || cmd.emit_final || emit_mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q      <= ST_OK;
			cell_cost_q   <= '0;
			is_obstacle_q <= 1'b0;
			out_row_q     <= '0;
			out_col_q     <= '0;
			found_q       <= 1'b0;
			last_q        <= 1'b1;
			if (cmd.emit_single) begin
				status_q <= single_status;
				if (single_read) begin
					cell_cost_q   <= rdata_q[COST_BITS-1:0];
					is_obstacle_q <= rd_obst;
				end
			end else if (pend_valid_q) begin
				out_row_q <= pend_r_q;
				out_col_q <= pend_c_q;
				found_q   <= 1'b1;
				last_q    <= cmd.emit_final;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign cell_cost   = cell_cost_q;
	assign is_obstacle = is_obstacle_q;
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign found       = found_q;
	assign last        = last_q;

	always_comb begin
		stat            = '0;
		stat.kind       = kind_q;
		stat.negative   = neg_q;
		stat.in_map     = in_map;
		stat.clear_last = (sweep_r_q == ROW_W'(MAX_ROWS - 1))
			&& (sweep_c_q == COL_W'(MAX_COLS - 1));
		stat.fill_last  = ((CFG_W'(sweep_r_q) + CFG_W'(1)) == nr_eff)
			&& ((CFG_W'(sweep_c_q) + CFG_W'(1)) == nc_eff);
		stat.cand_valid = cand_valid;
		stat.nb_last    = (dr_q == D_HI) && (dc_q == D_HI);
		stat.rd_obst    = rd_obst;
		stat.pend_valid = pend_valid_q;
		stat.out_free   = out_free;
	end

	`GCM_ASSERT(a_emit_room, emit |-> out_free, "result written into a full output register")
	`GCM_ASSERT(a_pend_neigh, pend_valid_q |-> kind_q == KIND_NEIGH, "held neighbour outside an expansion")
	`GCM_ASSERT(a_fill_wrap, (cmd.fill_wr && stat.fill_last) |=> (sweep_r_q == '0 && sweep_c_q == '0), "sweep counters not back at the origin after a fill")

endmodule

// ----- src/grid_cost_map_neighbour_engine_top.sv -----
// Top level of the grid cost map with neighbour expansion.
//
//   channel  handshake               payload
//   in       in_valid / in_ready     kind, row, col, cost_value, diagonal
//   out      out_valid / out_ready   status, cell_cost, is_obstacle, out_row, out_col,
//                                    found, last
//   cfg      cfg_valid / cfg_ready   cfg_index (0 rows, 1 columns), cfg_data
//
// After reset a clearing pass writes all 4096 cells, one per cycle, with in_ready low.
// Set cost, set obstacle and read pass through capture, dispatch and response; a fill with
// a non-negative cost first sweeps rows*cols cells. Expansion steps through the window
// positions with one memory read per candidate, bounded by the single read port of the cell memory.
// The output register frees in_ready-side work from the consumer; a stall holds only the
// step that needs to write a new word into a full output register.
module grid_cost_map_neighbour_engine_top import gcm_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [KIND_W-1:0]           kind,
	input  logic [ROW_W-1:0]            row,
	input  logic [COL_W-1:0]            col,
	input  logic signed [COST_IN_W-1:0] cost_value,
	input  logic                        diagonal,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [STATUS_W-1:0]         status,
	output logic [COST_BITS-1:0]        cell_cost,
	output logic                        is_obstacle,
	output logic [ROW_W-1:0]            out_row,
	output logic [COL_W-1:0]            out_col,
	output logic                        found,
	output logic                        last,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	gcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gcm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.kind        (kind),
		.row         (row),
		.col         (col),
		.cost_value  (cost_value),
		.diagonal    (diagonal),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.cell_cost   (cell_cost),
		.is_obstacle (is_obstacle),
		.out_row     (out_row),
		.out_col     (out_col),
		.found       (found),
		.last        (last)
	);

endmodule
